@@ hw/rtl/sfs_pkg.sv @@
// Shared types and constants for the sampled frame statistics block.
// No dependencies; every other file of the block but sfs_checker imports this package.
package sfs_pkg;

   localparam logic [31:0] HASH_BASIS         = 32'h811c_9dc5;
   localparam logic [31:0] HASH_PRIME         = 32'd16777619;
   localparam logic [31:0] FRAME_LENGTH_RESET = 32'd614400;
   localparam logic [7:0]  LEVEL_MAX          = 8'hFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // One classified byte passed from the front end to the back end.
   typedef struct packed {
      logic [7:0] pixel;
      logic       sample;
      logic       last;
   } sfs_entry_type;

endpackage

@@ hw/rtl/sfs_front.sv @@
// Front end: frame length register, sampling step, byte position and phase
// tracking. Classifies each accepted byte. Depends on sfs_pkg.
module sfs_front #(
   parameter int SAMPLE_GOAL = 4096,
   parameter int LENGTH_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [LENGTH_BITS-1:0]   csr_wdata,
   input  logic                     req_push,
   input  logic [7:0]               req_pixel_byte,
   output logic                     req_full,
   input  logic                     q_full,
   output logic                     q_push,
   output sfs_pkg::sfs_entry_type   q_entry
);
   import sfs_pkg::*;

   localparam int GOAL_LOG    = $clog2(SAMPLE_GOAL);
   localparam int STEP_RAW    = LENGTH_BITS - GOAL_LOG + 1;
   localparam int STEP_W      = (STEP_RAW < 1) ? 1 : STEP_RAW;
   localparam int RECIP_SHIFT = LENGTH_BITS + GOAL_LOG;
   localparam int PROD_W      = 2 * LENGTH_BITS + 1;

   localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) / SAMPLE_GOAL) + 64'd1;

   localparam longint unsigned LEN_MASK      = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam longint unsigned RESET_LEN     = 64'(FRAME_LENGTH_RESET) & LEN_MASK;
   localparam longint unsigned RESET_LEN_EFF = (RESET_LEN == 0) ? 64'd1 : RESET_LEN;
   localparam longint unsigned RESET_QUOT    = RESET_LEN_EFF / SAMPLE_GOAL;
   localparam longint unsigned RESET_STEP    = (RESET_QUOT == 0) ? 64'd1 : RESET_QUOT;

   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic [STEP_W-1:0]      phase_ff, phase_in;

   logic [LENGTH_BITS-1:0] len_eff;
   logic [LENGTH_BITS-1:0] wdata_eff;
   logic [LENGTH_BITS:0]   pos_inc;
   logic [STEP_W:0]        phase_inc;
   logic                   accept;
   logic                   is_last;
   logic [PROD_W-1:0]      step_prod;
   logic [STEP_W-1:0]      step_quot;

   assign req_full = q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = accept;

   assign len_eff   = (len_ff == '0) ? LENGTH_BITS'(1) : len_ff;
   assign wdata_eff = (csr_wdata == '0) ? LENGTH_BITS'(1) : csr_wdata;
   assign pos_inc   = {1'b0, pos_ff} + (LENGTH_BITS+1)'(1);
   assign phase_inc = {1'b0, phase_ff} + (STEP_W+1)'(1);
   assign is_last   = (pos_inc >= {1'b0, len_eff});

   assign q_entry.pixel  = req_pixel_byte;
   assign q_entry.sample = (phase_ff == '0);
   assign q_entry.last   = is_last;

   // The step is the written length over the sample goal. A rounded-up
   // reciprocal scaled past the length width gives the exact floor for every
   // length that fits the register.
   assign step_prod = PROD_W'(wdata_eff) * PROD_W'(RECIP);
   assign step_quot = step_prod[RECIP_SHIFT +: STEP_W];

   always_comb begin
      len_in   = len_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;

      if (csr_wen) begin
         len_in  = csr_wdata;
         step_in = (step_quot == '0) ? STEP_W'(1) : step_quot;
      end

      if (accept) begin
         if (is_last) begin
            pos_in   = '0;
            phase_in = '0;
         end else begin
            pos_in   = pos_inc[LENGTH_BITS-1:0];
            // A shortened step can leave the phase above it; wrap to zero then.
            phase_in = (phase_inc >= {1'b0, step_ff}) ? '0 : phase_inc[STEP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LENGTH_BITS'(RESET_LEN);
         step_ff  <= STEP_W'(RESET_STEP);
         pos_ff   <= '0;
         phase_ff <= '0;
      end else begin
         len_ff   <= len_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ hw/rtl/sfs_queue.sv @@
// Short queue of classified words between the front end and the back end.
// Depends on sfs_pkg for the entry type and depth.
module sfs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sfs_pkg::sfs_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output sfs_pkg::sfs_entry_type head_entry
);
   import sfs_pkg::*;

   sfs_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & ~empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/sfs_back.sv @@
// Back end: hash, sum, minimum, maximum and count accumulation, the serial
// mean divider and the result register. Depends on sfs_pkg.
module sfs_back #(
   parameter int SAMPLE_GOAL = 4096,
   parameter int LENGTH_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  sfs_pkg::sfs_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [31:0]            rsp_hash_value,
   output logic [7:0]             rsp_mean_level,
   output logic [7:0]             rsp_min_level,
   output logic [7:0]             rsp_max_level,
   output logic [$clog2(2*SAMPLE_GOAL)-1:0] rsp_sample_total
);
   import sfs_pkg::*;

   localparam int OUT_CNT_W = $clog2(2 * SAMPLE_GOAL);
   localparam int CNT_W     = (LENGTH_BITS + 1 > 32) ? 32 : LENGTH_BITS + 1;
   localparam int SUM_W     = (LENGTH_BITS + 9 > 32) ? 32 : LENGTH_BITS + 9;
   localparam int DIV_W     = (SUM_W > CNT_W + 7) ? SUM_W : CNT_W + 7;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   div_state_type     div_state_ff, div_state_in;
   logic [31:0]       hash_ff, hash_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [7:0]        min_ff, min_in;
   logic [7:0]        max_ff, max_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [2:0]        dstep_ff, dstep_in;
   logic [DIV_W-1:0]  drem_ff, drem_in;
   logic [DIV_W-1:0]  dsor_ff, dsor_in;
   logic [7:0]        dquot_ff, dquot_in;
   logic [31:0]       dhash_ff, dhash_in;
   logic [7:0]        dmin_ff, dmin_in;
   logic [7:0]        dmax_ff, dmax_in;
   logic [CNT_W-1:0]  dcnt_ff, dcnt_in;

   logic              out_valid_ff, out_valid_in;
   logic [31:0]       out_hash_ff, out_hash_in;
   logic [7:0]        out_mean_ff, out_mean_in;
   logic [7:0]        out_min_ff, out_min_in;
   logic [7:0]        out_max_ff, out_max_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   logic [31:0]       hash_upd;
   logic [SUM_W-1:0]  sum_upd;
   logic [7:0]        min_upd;
   logic [7:0]        max_upd;
   logic [CNT_W-1:0]  cnt_upd;
   logic [31:0]       hash_prod;
   logic              rem_ge;
   logic              out_load;
   logic              out_take;

   assign out_take = rsp_pop & out_valid_ff;
   // A frame end waits at the head of the queue until the divider is free.
   assign q_pop    = ~q_empty & (~q_entry.last | (div_state_ff == DIV_IDLE));
   assign out_load = (div_state_ff == DIV_HOLD) & (~out_valid_ff | rsp_pop);

   assign hash_prod = (hash_ff ^ {24'b0, q_entry.pixel}) * HASH_PRIME;

   always_comb begin
      hash_upd = hash_ff;
      sum_upd  = sum_ff;
      min_upd  = min_ff;
      max_upd  = max_ff;
      cnt_upd  = cnt_ff;
      if (q_entry.sample) begin
         hash_upd = hash_prod;
         sum_upd  = sum_ff + SUM_W'(q_entry.pixel);
         min_upd  = (q_entry.pixel < min_ff) ? q_entry.pixel : min_ff;
         max_upd  = (q_entry.pixel > max_ff) ? q_entry.pixel : max_ff;
         cnt_upd  = cnt_ff + CNT_W'(1);
      end
   end

   assign rem_ge = (drem_ff >= dsor_ff);

   always_comb begin
      div_state_in = div_state_ff;
      hash_in      = hash_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      cnt_in       = cnt_ff;
      dstep_in     = dstep_ff;
      drem_in      = drem_ff;
      dsor_in      = dsor_ff;
      dquot_in     = dquot_ff;
      dhash_in     = dhash_ff;
      dmin_in      = dmin_ff;
      dmax_in      = dmax_ff;
      dcnt_in      = dcnt_ff;
      out_valid_in = out_valid_ff & ~out_take;
      out_hash_in  = out_hash_ff;
      out_mean_in  = out_mean_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      out_cnt_in   = out_cnt_ff;

      unique case (div_state_ff)
         DIV_IDLE: begin
         end
         DIV_RUN: begin
            // The mean is below 256, so eight shifted compares find it.
            drem_in  = rem_ge ? drem_ff - dsor_ff : drem_ff;
            dquot_in = {dquot_ff[6:0], rem_ge};
            dsor_in  = dsor_ff >> 1;
            dstep_in = dstep_ff - 3'd1;
            if (dstep_ff == 3'd0) begin
               div_state_in = DIV_HOLD;
            end
         end
         DIV_HOLD: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_hash_in  = dhash_ff;
               out_mean_in  = (dcnt_ff == '0) ? 8'd0 : dquot_ff;
               out_min_in   = dmin_ff;
               out_max_in   = dmax_ff;
               out_cnt_in   = OUT_CNT_W'(dcnt_ff);
               div_state_in = DIV_IDLE;
            end
         end
         default: begin
            div_state_in = DIV_IDLE;
         end
      endcase

      if (q_pop) begin
         if (q_entry.last) begin
            dhash_in     = hash_upd;
            dmin_in      = min_upd;
            dmax_in      = max_upd;
            dcnt_in      = cnt_upd;
            drem_in      = DIV_W'(sum_upd);
            dsor_in      = DIV_W'(cnt_upd) << 7;
            dquot_in     = '0;
            dstep_in     = 3'd7;
            div_state_in = DIV_RUN;
            hash_in      = HASH_BASIS;
            sum_in       = '0;
            min_in       = LEVEL_MAX;
            max_in       = '0;
            cnt_in       = '0;
         end else begin
            hash_in = hash_upd;
            sum_in  = sum_upd;
            min_in  = min_upd;
            max_in  = max_upd;
            cnt_in  = cnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff <= DIV_IDLE;
         hash_ff      <= HASH_BASIS;
         sum_ff       <= '0;
         min_ff       <= LEVEL_MAX;
         max_ff       <= '0;
         cnt_ff       <= '0;
         dstep_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         div_state_ff <= div_state_in;
         hash_ff      <= hash_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         cnt_ff       <= cnt_in;
         dstep_ff     <= dstep_in;
         out_valid_ff <= out_valid_in;
      end
      drem_ff     <= drem_in;
      dsor_ff     <= dsor_in;
      dquot_ff    <= dquot_in;
      dhash_ff    <= dhash_in;
      dmin_ff     <= dmin_in;
      dmax_ff     <= dmax_in;
      dcnt_ff     <= dcnt_in;
      out_hash_ff <= out_hash_in;
      out_mean_ff <= out_mean_in;
      out_min_ff  <= out_min_in;
      out_max_ff  <= out_max_in;
      out_cnt_ff  <= out_cnt_in;
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_hash_value   = out_hash_ff;
   assign rsp_mean_level   = out_mean_ff;
   assign rsp_min_level    = out_min_ff;
   assign rsp_max_level    = out_max_ff;
   assign rsp_sample_total = out_cnt_ff;

endmodule

@@ hw/rtl/sampled_frame_statistics.sv @@
// Sampled frame statistics, top level: front end, word queue and back end.
// Depends on sfs_pkg, sfs_front, sfs_queue and sfs_back.
//
// Usage: bytes of a frame arrive on req_pixel_byte, one word per push while
// req_full is low. csr_wdata written with csr_wen sets the frame length; zero
// counts as one. Every step-th byte is sampled, the step being the length
// divided by SAMPLE_GOAL (at least one). After the last byte of a frame one
// result word (hash, mean, minimum, maximum, sample count) appears on the rsp_
// ports while rsp_empty is low and leaves on rsp_pop.
// Throughput: one byte per cycle while req_full is low. A result is ready once
// the frame end has left the queue, run through the serial mean divider and
// loaded the result register, which waits while an earlier result is held.
// The divider takes one frame end at a time, so a later frame end waits at
// the head of the queue while the bytes behind it wait in the queue.
// A length write takes effect from the next word on, with no stall.
// Reset clears the frame, empties the queue and result register and restores
// the default frame length. If the receiver stalls, the next frame is still
// accumulated; a further frame end waits in the four-word queue, and req_full
// rises once that queue fills.
module sampled_frame_statistics #(
   parameter int SAMPLE_GOAL = 4096,
   parameter int LENGTH_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [LENGTH_BITS-1:0] csr_wdata,
   input  logic                   req_push,
   input  logic [7:0]             req_pixel_byte,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [31:0]            rsp_hash_value,
   output logic [7:0]             rsp_mean_level,
   output logic [7:0]             rsp_min_level,
   output logic [7:0]             rsp_max_level,
   output logic [$clog2(2*SAMPLE_GOAL)-1:0] rsp_sample_total
);
   import sfs_pkg::*;

   sfs_entry_type push_entry;
   sfs_entry_type head_entry;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;

   sfs_front #(
      .SAMPLE_GOAL(SAMPLE_GOAL),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .req_push      (req_push),
      .req_pixel_byte(req_pixel_byte),
      .req_full      (req_full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   sfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_entry(head_entry)
   );

   sfs_back #(
      .SAMPLE_GOAL(SAMPLE_GOAL),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_entry         (head_entry),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_hash_value  (rsp_hash_value),
      .rsp_mean_level  (rsp_mean_level),
      .rsp_min_level   (rsp_min_level),
      .rsp_max_level   (rsp_max_level),
      .rsp_sample_total(rsp_sample_total)
   );

endmodule

@@ hw/rtl/sfs_checker.sv @@
// Port-level checks for the sampled frame statistics block, attached to the
// top level by the bind at the end. Depends on sampled_frame_statistics.
module sfs_checker #(
   parameter int SAMPLE_GOAL = 4096,
   parameter int LENGTH_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input logic [31:0]            rsp_hash_value,
   input logic [7:0]             rsp_mean_level,
   input logic [7:0]             rsp_min_level,
   input logic [7:0]             rsp_max_level,
   input logic [$clog2(2*SAMPLE_GOAL)-1:0] rsp_sample_total
);

   // Reset leaves no result word behind.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // A waiting result word stays, with its hash, mean and sample count held, until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hash_value)
         && $stable(rsp_mean_level) && $stable(rsp_sample_total)))
      else $error("result word changed while stalled");

   // Every frame samples its first byte, so the extremes are ordered and the
   // mean lies between them.
   a_levels: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_min_level <= rsp_max_level
         && rsp_mean_level >= rsp_min_level && rsp_mean_level <= rsp_max_level))
      else $error("inconsistent levels in result word");

endmodule

bind sampled_frame_statistics sfs_checker #(
   .SAMPLE_GOAL(SAMPLE_GOAL),
   .LENGTH_BITS(LENGTH_BITS)
) u_sfs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_hash_value  (rsp_hash_value),
   .rsp_mean_level  (rsp_mean_level),
   .rsp_min_level   (rsp_min_level),
   .rsp_max_level   (rsp_max_level),
   .rsp_sample_total(rsp_sample_total)
);

@@ verif/sfs_stats_checker.sv @@
`timescale 1ns / 100ps
// Checker for the sampled frame statistics block: watches the byte, result and
// length ports, predicts each frame's statistics and compares. Uses sfs_pkg.
module sfs_stats_checker #(
   parameter int SAMPLE_GOAL = 4096,
   parameter int LENGTH_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [LENGTH_BITS-1:0] csr_wdata,
   input  logic                   req_push,
   input  logic [7:0]             req_pixel_byte,
   input  logic                   req_full,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  logic [31:0]            rsp_hash_value,
   input  logic [7:0]             rsp_mean_level,
   input  logic [7:0]             rsp_min_level,
   input  logic [7:0]             rsp_max_level,
   input  logic [$clog2(2*SAMPLE_GOAL)-1:0] rsp_sample_total,
   output int                     fail_count,
   output int                     pending_count
);
   import sfs_pkg::*;

   localparam int TOTAL_W     = $clog2(2*SAMPLE_GOAL);
   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic [31:0]        hash_value;
      logic [7:0]         mean_level;
      logic [7:0]         min_level;
      logic [7:0]         max_level;
      logic [TOTAL_W-1:0] sample_total;
   } frame_stats_type;

   logic [LENGTH_BITS-1:0] length_reg;
   logic [LENGTH_BITS-1:0] byte_pos;
   logic [TOTAL_W-1:0]     phase;
   logic [31:0]            hash_acc;
   logic [31:0]            sum_acc;
   logic [7:0]             min_acc;
   logic [7:0]             max_acc;
   logic [31:0]            count_acc;
   frame_stats_type        expected_stats[$];
   frame_stats_type        wanted;
   int                     failures = 0;

   task automatic clear_frame();
      byte_pos  = '0;
      phase     = '0;
      hash_acc  = HASH_BASIS;
      sum_acc   = '0;
      min_acc   = LEVEL_MAX;
      max_acc   = '0;
      count_acc = '0;
   endtask

   // Folds one byte into the running statistics and queues a summary when the
   // byte closes the frame. A zero length counts as a length of one.
   task automatic absorb_byte(input logic [7:0] level);
      longint unsigned len_eff;
      longint unsigned step;
      logic [31:0]     quotient;
      frame_stats_type summary;
      logic            last;
      len_eff = (length_reg == 0) ? 1 : longint'(length_reg);
      step    = len_eff / SAMPLE_GOAL;
      if (step == 0) step = 1;
      if (phase == 0) begin
         hash_acc  = (hash_acc ^ {24'd0, level}) * HASH_PRIME;
         sum_acc   = sum_acc + 32'(level);
         if (level < min_acc) min_acc = level;
         if (level > max_acc) max_acc = level;
         count_acc = count_acc + 32'd1;
      end
      phase = phase + 1'b1;
      // A step shortened mid-frame can leave the phase above it.
      if (phase >= step) phase = '0;
      last     = (longint'(byte_pos) + 1) >= len_eff;
      byte_pos = byte_pos + 1'b1;
      if (last) begin
         quotient             = (count_acc != 0) ? sum_acc / count_acc : '0;
         summary.hash_value   = hash_acc;
         summary.mean_level   = quotient[7:0];
         summary.min_level    = min_acc;
         summary.max_level    = max_acc;
         summary.sample_total = count_acc[TOTAL_W-1:0];
         expected_stats.push_back(summary);
         clear_frame();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $error("%s: expected %0h, actual %0h", name, want, seen);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         length_reg = LENGTH_BITS'(FRAME_LENGTH_RESET);
         clear_frame();
         expected_stats.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_stats.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("result word popped while no frame was pending");
            end else begin
               wanted = expected_stats.pop_front();
               check_field("hash_value", wanted.hash_value, rsp_hash_value);
               check_field("mean_level", 32'(wanted.mean_level), 32'(rsp_mean_level));
               check_field("min_level", 32'(wanted.min_level), 32'(rsp_min_level));
               check_field("max_level", 32'(wanted.max_level), 32'(rsp_max_level));
               check_field("sample_total", 32'(wanted.sample_total),
                           32'(rsp_sample_total));
            end
         end
         if (req_push && !req_full) absorb_byte(req_pixel_byte);
         if (csr_wen) length_reg = csr_wdata;
      end
      pending_count <= expected_stats.size();
      fail_count    <= failures;
   end

endmodule

@@ verif/sampled_frame_statistics_tb.sv @@
`timescale 1ns / 100ps
// Top of the sampled frame statistics testbench: clock, reset, byte and length
// stimulus, result draining and the verdict. Uses sfs_pkg and sfs_stats_checker.
module sampled_frame_statistics_tb;
   import sfs_pkg::*;

   localparam int LENGTH_BITS    = 24;
   localparam int SAMPLE_GOAL    = 4096;
   localparam int TOTAL_W        = $clog2(2*SAMPLE_GOAL);
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_ITEMS   = 380;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_wen        = 1'b0;
   logic [LENGTH_BITS-1:0] csr_wdata      = '0;
   logic                   req_push       = 1'b0;
   logic [7:0]             req_pixel_byte = '0;
   logic                   rsp_pop        = 1'b0;
   logic                   req_full;
   logic                   rsp_empty;
   logic [31:0]            rsp_hash_value;
   logic [7:0]             rsp_mean_level;
   logic [7:0]             rsp_min_level;
   logic [7:0]             rsp_max_level;
   logic [TOTAL_W-1:0]     rsp_sample_total;
   int                     fail_count;
   int                     pending_count;

   int          bytes_sent    = 0;
   int unsigned frame_pos     = 0;
   int unsigned cur_len       = FRAME_LENGTH_RESET;
   int          burst_left    = 0;
   bit          stall_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sampled_frame_statistics #(
      .SAMPLE_GOAL(SAMPLE_GOAL),
      .LENGTH_BITS(LENGTH_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_pixel_byte  (req_pixel_byte),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_hash_value  (rsp_hash_value),
      .rsp_mean_level  (rsp_mean_level),
      .rsp_min_level   (rsp_min_level),
      .rsp_max_level   (rsp_max_level),
      .rsp_sample_total(rsp_sample_total)
   );

   sfs_stats_checker #(
      .SAMPLE_GOAL(SAMPLE_GOAL),
      .LENGTH_BITS(LENGTH_BITS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .req_push        (req_push),
      .req_pixel_byte  (req_pixel_byte),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_hash_value  (rsp_hash_value),
      .rsp_mean_level  (rsp_mean_level),
      .rsp_min_level   (rsp_min_level),
      .rsp_max_level   (rsp_max_level),
      .rsp_sample_total(rsp_sample_total),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Bytes still needed to close the current frame under the current length.
   function automatic int unsigned bytes_to_end();
      int unsigned eff;
      eff = (cur_len == 0) ? 1 : cur_len;
      return (frame_pos >= eff) ? 1 : eff - frame_pos;
   endfunction

   // Offers one word and returns at the edge that accepts it, with push left
   // high so that a following word can go out without a gap.
   task automatic send_byte(input logic [7:0] level);
      int unsigned eff;
      req_push       <= 1'b1;
      req_pixel_byte <= level;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
      eff = (cur_len == 0) ? 1 : cur_len;
      frame_pos = (frame_pos + 1 >= eff) ? 0 : frame_pos + 1;
   endtask

   task automatic push_bytes(input int count);
      int gap;
      repeat (count) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
               gap = $urandom_range(1, 8);
               req_push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         send_byte(random_level());
      end
   endtask

   // Waits until every predicted result has left, then lets the back end
   // finish whatever it still holds.
   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LENGTH_BITS-1:0] value);
      drain_results();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      cur_len = value;
   endtask

   // Receiver: stretches of steady, loose and sparse popping, with one long
   // hold-off once the sender asks for it.
   initial begin
      int mode;
      int run;
      bit held_off;
      held_off = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         run  = $urandom_range(5, 60);
         repeat (run) begin
            @(posedge clock);
            if (stall_request && !held_off) begin
               held_off = 1'b1;
               rsp_pop <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end
            case (mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               2:       rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      int start_count;
      int kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Under the reset length only the first byte is sampled; shortening the
      // length past the position ends the frame on the next byte, with the
      // phase above the new step.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      write_length(LENGTH_BITS'(2));
      push_bytes(bytes_to_end());

      // Zero length: every word is a frame of its own.
      write_length('0);
      send_byte(8'h00);
      send_byte(8'hFF);
      write_length(LENGTH_BITS'(1));
      send_byte(8'h5A);

      write_length(LENGTH_BITS'(4));
      repeat (4) send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'hFE);

      // Largest length gives the widest step; it is then cut down twice.
      write_length(LENGTH_MAX);
      repeat (7) send_byte(random_level());
      write_length(LENGTH_BITS'(8192));
      repeat (3) send_byte(random_level());
      write_length(LENGTH_BITS'(5));
      push_bytes(bytes_to_end());

      // Fill the block while the receiver holds off, so that full rises.
      write_length('0);
      stall_request = 1'b1;
      repeat (16) send_byte(random_level());

      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            write_length(LENGTH_BITS'($urandom_range(1, 48)));
            repeat ($urandom_range(1, 4)) push_bytes(bytes_to_end());
         end else if (kind == 6) begin
            write_length('0);
            push_bytes($urandom_range(1, 6));
         end else if (kind <= 8) begin
            write_length(LENGTH_BITS'($urandom) | LENGTH_BITS'(24'h00_2000));
            push_bytes($urandom_range(1, 24));
            write_length(LENGTH_BITS'($urandom_range(1, 32)));
            push_bytes(bytes_to_end());
         end else begin
            // Leave a frame half done; the next length write lands mid-frame.
            write_length(LENGTH_BITS'($urandom_range(2, 48)));
            push_bytes($urandom_range(1, cur_len - 1));
         end
      end

      drain_results();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
